@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/bbs_pkg.sv @@
`default_nettype none

package bbs_pkg;

   localparam int MAX_BLOCK = 64;
   localparam int MIN_BLOCK = 3;
   localparam int RESET_BLOCK = 4;
   localparam int POS_W = $clog2(MAX_BLOCK);
   localparam int CNT_W = POS_W + 1;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      RULE_ALL   = 2'd0,
      RULE_ODD   = 2'd1,
      RULE_THIRD = 2'd2
   } rule_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   typedef struct packed {
      logic data_bit;
      logic end_of_data;
   } req_type;

   typedef struct packed {
      logic code_bit;
      logic run_last;
      logic stream_done;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/block_bit_scrambler.sv @@
// Block bit scrambler.
// The req channel carries one plaintext bit per transfer with an end-of-data
// flag; the rsp channel carries encoded bits. Both use valid and stall. The
// csr channel (valid and ready, always ready) writes mode (index 0) and
// block_size (index 1); the user must write it only while the block is idle,
// which the block itself does not enforce. In mode 0 every transfer yields
// one encoded bit in the output register in the cycle after the transfer, so a
// bit is taken every cycle while rsp is free. In mode 1 bits are stored and
// no result appears until the block closes; then the last bit is sent first
// and the stored bits follow, each by a registered read from the block memory
// and then an output load. No new bit is taken until the replay is done.
// Reset clears the position, ones count, rule and control state; the block
// memory is not cleared, since every entry is written before it is read.
// When the receiver stalls, the output register holds its bit and the
// block stops taking bits and stops the replay until the stall is released.
`default_nettype none

module block_bit_scrambler (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  bbs_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output bbs_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [bbs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [bbs_pkg::CSR_DATA_W-1:0]       csr_data
);

   bbs_pkg::state_type             state_ff, state_in;
   bbs_pkg::rule_type              rule_ff, rule_in;
   logic                           mode_ff, mode_in;
   logic [bbs_pkg::CSR_DATA_W-1:0] block_size_ff, block_size_in;
   logic [bbs_pkg::POS_W-1:0]      position_ff, position_in;
   logic [1:0]                     pos_mod3_ff, pos_mod3_in;
   logic [bbs_pkg::CNT_W-1:0]      ones_ff, ones_in;
   logic [bbs_pkg::POS_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [bbs_pkg::POS_W-1:0]      last_idx_ff, last_idx_in;
   logic                           eod_ff, eod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bbs_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                           rd_data_ff;
   logic                           block_store_ff [bbs_pkg::MAX_BLOCK];

   logic                           req_fire;
   logic                           slot_free;
   logic [bbs_pkg::CNT_W-1:0]      size;
   logic [bbs_pkg::CNT_W-1:0]      count_n;
   logic [bbs_pkg::CNT_W-1:0]      ones_new;
   logic [bbs_pkg::CNT_W:0]        ones_twice;
   logic [bbs_pkg::CNT_W:0]        count_ext;
   logic                           closes;
   logic                           flip;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != bbs_pkg::ST_IDLE) || !slot_free;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (block_size_ff < bbs_pkg::CSR_DATA_W'(bbs_pkg::MIN_BLOCK)) begin
         size = bbs_pkg::CNT_W'(bbs_pkg::MIN_BLOCK);
      end else if (block_size_ff > bbs_pkg::CSR_DATA_W'(bbs_pkg::MAX_BLOCK)) begin
         size = bbs_pkg::CNT_W'(bbs_pkg::MAX_BLOCK);
      end else begin
         size = bbs_pkg::CNT_W'(block_size_ff);
      end
   end

   assign count_n    = {1'b0, position_ff} + bbs_pkg::CNT_W'(1);
   assign ones_new   = ones_ff + bbs_pkg::CNT_W'(req_data.data_bit);
   assign ones_twice = {ones_new, 1'b0};
   assign count_ext  = {1'b0, count_n};
   assign closes     = req_data.end_of_data || (count_n >= size);

   always_comb begin
      case (rule_ff)
         bbs_pkg::RULE_ODD:   flip = position_ff[0];
         bbs_pkg::RULE_THIRD: flip = (pos_mod3_ff == 2'd2);
         default:             flip = 1'b1;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      block_size_in = block_size_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bbs_pkg::CSR_MODE:       mode_in = csr_data[0];
            bbs_pkg::CSR_BLOCK_SIZE: block_size_in = csr_data;
            default:                 ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rule_in      = rule_ff;
      position_in  = position_ff;
      pos_mod3_in  = pos_mod3_ff;
      ones_in      = ones_ff;
      rd_idx_in    = rd_idx_ff;
      last_idx_in  = last_idx_ff;
      eod_in       = eod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         bbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!mode_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.code_bit    = req_data.data_bit ^ flip;
                  rsp_data_in.run_last    = 1'b1;
                  rsp_data_in.stream_done = req_data.end_of_data;
               end else if (closes) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.code_bit    = req_data.data_bit;
                  rsp_data_in.run_last    = (position_ff == '0);
                  rsp_data_in.stream_done = req_data.end_of_data && (position_ff == '0);
                  rd_idx_in               = '0;
                  last_idx_in             = position_ff - bbs_pkg::POS_W'(1);
                  eod_in                  = req_data.end_of_data;
                  if (position_ff != '0) begin
                     state_in = bbs_pkg::ST_READ;
                  end
               end
               if (closes) begin
                  if (req_data.end_of_data || (ones_twice == count_ext)) begin
                     rule_in = bbs_pkg::RULE_ALL;
                  end else if (ones_twice < count_ext) begin
                     rule_in = bbs_pkg::RULE_ODD;
                  end else begin
                     rule_in = bbs_pkg::RULE_THIRD;
                  end
                  position_in = '0;
                  pos_mod3_in = 2'd0;
                  ones_in     = '0;
               end else begin
                  position_in = position_ff + bbs_pkg::POS_W'(1);
                  pos_mod3_in = (pos_mod3_ff == 2'd2) ? 2'd0 : pos_mod3_ff + 2'd1;
                  ones_in     = ones_new;
               end
            end
         end
         bbs_pkg::ST_READ: begin
            state_in = bbs_pkg::ST_SEND;
         end
         bbs_pkg::ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.code_bit    = rd_data_ff;
               rsp_data_in.run_last    = (rd_idx_ff == last_idx_ff);
               rsp_data_in.stream_done = eod_ff && (rd_idx_ff == last_idx_ff);
               if (rd_idx_ff == last_idx_ff) begin
                  state_in = bbs_pkg::ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + bbs_pkg::POS_W'(1);
                  state_in  = bbs_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = bbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bbs_pkg::ST_IDLE;
         rule_ff       <= bbs_pkg::RULE_ALL;
         mode_ff       <= 1'b0;
         block_size_ff <= bbs_pkg::CSR_DATA_W'(bbs_pkg::RESET_BLOCK);
         position_ff   <= '0;
         pos_mod3_ff   <= 2'd0;
         ones_ff       <= '0;
         rd_idx_ff     <= '0;
         last_idx_ff   <= '0;
         eod_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rule_ff       <= rule_in;
         mode_ff       <= mode_in;
         block_size_ff <= block_size_in;
         position_ff   <= position_in;
         pos_mod3_ff   <= pos_mod3_in;
         ones_ff       <= ones_in;
         rd_idx_ff     <= rd_idx_in;
         last_idx_ff   <= last_idx_in;
         eod_ff        <= eod_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         block_store_ff[position_ff] <= req_data.data_bit;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= block_store_ff[rd_idx_ff];
   end

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_no_take_in_replay, clock, reset, state_ff != bbs_pkg::ST_IDLE, req_stall)
   `ASSERT_IMPLIES(a_replay_index, clock, reset, state_ff != bbs_pkg::ST_IDLE, rd_idx_ff <= last_idx_ff)
   `ASSERT_IMPLIES(a_done_is_last, clock, reset, rsp_valid_ff && rsp_data_ff.stream_done, rsp_data_ff.run_last)
   `ASSERT_ALWAYS(a_mod3_range, clock, reset, pos_mod3_ff != 2'd3)

endmodule

`default_nettype wire
